FILE: rtl/core/circular_deque_macros.svh
// assertion macros for the circular deque
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cdq_pkg.sv
// types, codes and constants shared across the circular deque
`timescale 1ns / 1ps
`default_nettype none
package cdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int OCC_W     = 4;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] popped_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load_rd;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_read;
    } t_ctl_sts;

endpackage
`default_nettype wire

FILE: rtl/core/cdq_datapath.sv
// deque datapath: indices, count, word store, cached end words and result register
`timescale 1ns / 1ps
`default_nettype none
module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cdq_pkg::t_ctl_cmd i_cmd,
    output cdq_pkg::t_ctl_sts      o_sts,
    input  wire cdq_pkg::t_in_item i_in_item,
    output cdq_pkg::t_out_item     o_out_item
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [1:0]                        r_op;
    logic signed [cdq_pkg::WORD_W-1:0] r_word;
    logic [IW-1:0]                     r_front_idx, n_front_idx;
    logic [IW-1:0]                     r_rear_idx, n_rear_idx;
    logic [CW-1:0]                     r_count, n_count;
    logic signed [cdq_pkg::WORD_W-1:0] r_front_word, n_front_word;
    logic signed [cdq_pkg::WORD_W-1:0] r_rear_word, n_rear_word;
    logic signed [cdq_pkg::WORD_W-1:0] r_rd_data;
    logic signed [cdq_pkg::WORD_W-1:0] r_mem [DEPTH];
    cdq_pkg::t_out_item                r_res, n_res;

    logic [IW-1:0]                     front_dec, front_inc, rear_dec, rear_inc;
    logic [IW-1:0]                     wr_addr, rd_addr;
    logic                              mem_we, need_read;
    logic                              is_push, is_empty_now, is_full_now;
    logic [1:0]                        status;
    logic signed [cdq_pkg::WORD_W-1:0] popped;

    assign front_dec = (r_front_idx == '0) ? LAST_IDX : r_front_idx - 1'b1;
    assign front_inc = (r_front_idx == LAST_IDX) ? '0 : r_front_idx + 1'b1;
    assign rear_dec  = (r_rear_idx == '0) ? LAST_IDX : r_rear_idx - 1'b1;
    assign rear_inc  = (r_rear_idx == LAST_IDX) ? '0 : r_rear_idx + 1'b1;

    assign is_push      = (r_op == cdq_pkg::OP_PUSH_FRONT) || (r_op == cdq_pkg::OP_PUSH_REAR);
    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == FULL_CNT);

    always_comb begin
        n_front_idx  = r_front_idx;
        n_rear_idx   = r_rear_idx;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_rear_word  = r_rear_word;
        wr_addr      = '0;
        rd_addr      = '0;
        mem_we       = 1'b0;
        need_read    = 1'b0;
        status       = cdq_pkg::ST_DONE;
        popped       = '0;
        priority if (is_push && is_full_now) begin
            status = cdq_pkg::ST_FULL;
        end else if (!is_push && is_empty_now) begin
            status = cdq_pkg::ST_EMPTY;
        end else if (is_push) begin
            mem_we  = 1'b1;
            n_count = r_count + 1'b1;
            priority if (is_empty_now) begin
                n_front_idx  = '0;
                n_rear_idx   = '0;
                wr_addr      = '0;
                n_front_word = r_word;
                n_rear_word  = r_word;
            end else if (r_op == cdq_pkg::OP_PUSH_FRONT) begin
                n_front_idx  = front_dec;
                wr_addr      = front_dec;
                n_front_word = r_word;
            end else begin
                n_rear_idx  = rear_inc;
                wr_addr     = rear_inc;
                n_rear_word = r_word;
            end
        end else begin
            n_count = r_count - 1'b1;
            if (r_op == cdq_pkg::OP_POP_FRONT) begin
                popped = r_front_word;
                if (r_count != CW'(1)) begin
                    n_front_idx = front_inc;
                    rd_addr     = front_inc;
                    need_read   = 1'b1;
                end
            end else begin
                popped = r_rear_word;
                if (r_count != CW'(1)) begin
                    n_rear_idx = rear_dec;
                    rd_addr    = rear_dec;
                    need_read  = 1'b1;
                end
            end
        end

        n_res.status       = status;
        n_res.popped_value = popped;
        n_res.front_value  = (n_count == '0) ? cdq_pkg::EMPTY_WORD : n_front_word;
        n_res.rear_value   = (n_count == '0) ? cdq_pkg::EMPTY_WORD : n_rear_word;
        n_res.is_empty     = (n_count == '0);
        n_res.is_full      = (n_count == FULL_CNT);
        n_res.occupancy    = cdq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_idx <= '0;
            r_rear_idx  <= '0;
            r_count     <= '0;
        end else if (i_cmd.exec) begin
            r_front_idx <= n_front_idx;
            r_rear_idx  <= n_rear_idx;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_in_item.opcode;
            r_word <= i_in_item.push_value;
        end
        if (i_cmd.exec) begin
            r_front_word <= n_front_word;
            r_rear_word  <= n_rear_word;
            r_res        <= n_res;
        end else if (i_cmd.load_rd) begin
            if (r_op == cdq_pkg::OP_POP_FRONT) begin
                r_front_word      <= r_rd_data;
                r_res.front_value <= r_rd_data;
            end else begin
                r_rear_word      <= r_rd_data;
                r_res.rear_value <= r_rd_data;
            end
        end
    end

    // word store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[wr_addr] <= r_word;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_sts.need_read = need_read;
    assign o_out_item      = r_res;

endmodule
`default_nettype wire

FILE: rtl/core/cdq_ctrl.sv
// deque controller: sequences accept, execute, store reload and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module cdq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire cdq_pkg::t_ctl_sts i_sts,
    output cdq_pkg::t_ctl_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.need_read ? S_READ : S_OUT;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.latch   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load_rd = (r_state == S_READ);

endmodule
`default_nettype wire

FILE: rtl/core/circular_deque.sv
// circular deque top level: controller and datapath
// one item in flight; the result register loads in the execute state, and a pop that
// reloads an end word from the store's registered read port updates it in a read state
// the next item is taken in the cycle after the result leaves
// synchronous active-low reset empties the deque; store contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_macros.svh"
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire cdq_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cdq_pkg::t_out_item     o_out_item
);

    cdq_pkg::t_ctl_cmd ctl_cmd;
    cdq_pkg::t_ctl_sts ctl_sts;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (ctl_sts),
        .o_cmd       (ctl_cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctl_cmd),
        .o_sts      (ctl_sts),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

    `CDQ_ASSERT_NOW(a_one_in_flight, o_out_valid, o_in_stall, "item accepted while result pending")
    `CDQ_ASSERT_NEXT(a_accept_stalls, i_in_valid && !o_in_stall, o_in_stall, "no stall after accept")
    `CDQ_ASSERT_NOW(a_not_empty_and_full, o_out_valid, !(o_out_item.is_empty && o_out_item.is_full), "result both empty and full")
    `CDQ_ASSERT_NOW(a_empty_ends, o_out_valid && o_out_item.is_empty, (o_out_item.front_value == cdq_pkg::EMPTY_WORD) && (o_out_item.rear_value == cdq_pkg::EMPTY_WORD), "empty result without empty marker")

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the circular deque: directed and random items
`timescale 1ns / 1ps
module tb_top;

    localparam int QDEPTH      = cdq_pkg::DEPTH_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 430;
    localparam logic signed [cdq_pkg::WORD_W-1:0] WORD_MIN =
        {1'b1, {(cdq_pkg::WORD_W-1){1'b0}}};
    localparam logic signed [cdq_pkg::WORD_W-1:0] WORD_MAX =
        {1'b0, {(cdq_pkg::WORD_W-1){1'b1}}};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    cdq_pkg::t_in_item  i_in_item = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    cdq_pkg::t_out_item o_out_item;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    // shadow deque
    logic signed [cdq_pkg::WORD_W-1:0] shadow_slots [QDEPTH];
    int                 shadow_head = 0;
    int                 shadow_tail = 0;
    int                 shadow_held = 0;
    cdq_pkg::t_out_item deque_outcomes_q [$];

    bit idle_on = 1'b1;
    int mismatches = 0;
    int n_checked = 0;
    int n_push = 0;
    int n_pop = 0;
    int n_full_rej = 0;
    int n_empty_rej = 0;
    int n_times_full = 0;

    circular_deque #(.DEPTH(QDEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [cdq_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return cdq_pkg::EMPTY_WORD;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::t_out_item deque_apply(cdq_pkg::t_in_item it);
        cdq_pkg::t_out_item r;
        r = '0;
        r.status = cdq_pkg::ST_DONE;
        if (it.opcode == cdq_pkg::OP_PUSH_FRONT || it.opcode == cdq_pkg::OP_PUSH_REAR) begin
            if (shadow_held == QDEPTH) begin
                r.status = cdq_pkg::ST_FULL;
            end else begin
                if (shadow_held == 0) begin
                    shadow_head = 0;
                    shadow_tail = 0;
                    shadow_slots[0] = it.push_value;
                end else if (it.opcode == cdq_pkg::OP_PUSH_FRONT) begin
                    shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
                    shadow_slots[shadow_head] = it.push_value;
                end else begin
                    shadow_tail = (shadow_tail + 1) % QDEPTH;
                    shadow_slots[shadow_tail] = it.push_value;
                end
                shadow_held++;
            end
        end else if (shadow_held == 0) begin
            r.status = cdq_pkg::ST_EMPTY;
        end else if (it.opcode == cdq_pkg::OP_POP_FRONT) begin
            r.popped_value = shadow_slots[shadow_head];
            if (shadow_held > 1) shadow_head = (shadow_head + 1) % QDEPTH;
            shadow_held--;
        end else begin
            r.popped_value = shadow_slots[shadow_tail];
            if (shadow_held > 1) shadow_tail = (shadow_tail + QDEPTH - 1) % QDEPTH;
            shadow_held--;
        end
        if (shadow_held == 0) begin
            r.front_value = cdq_pkg::EMPTY_WORD;
            r.rear_value  = cdq_pkg::EMPTY_WORD;
        end else begin
            r.front_value = shadow_slots[shadow_head];
            r.rear_value  = shadow_slots[shadow_tail];
        end
        r.is_empty  = (shadow_held == 0);
        r.is_full   = (shadow_held == QDEPTH);
        r.occupancy = shadow_held[cdq_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic issue_op(input logic [1:0] op,
                            input logic signed [cdq_pkg::WORD_W-1:0] val);
        int gap;
        cdq_pkg::t_in_item it;
        cdq_pkg::t_out_item outcome;
        gap = idle_on ? pick_gap() : 0;
        it.opcode = op;
        it.push_value = val;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        outcome = deque_apply(it);
        deque_outcomes_q.push_back(outcome);
        if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR) n_push++;
        else n_pop++;
        if (outcome.status == cdq_pkg::ST_FULL) n_full_rej++;
        if (outcome.status == cdq_pkg::ST_EMPTY) n_empty_rej++;
        if (outcome.status == cdq_pkg::ST_DONE && outcome.is_full) n_times_full++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (deque_outcomes_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [cdq_pkg::WORD_W-1:0] want,
                                 input logic [cdq_pkg::WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
                     want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        cdq_pkg::t_out_item want;
        if (i_rst_n && out_fire) begin
            if (deque_outcomes_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, actual %0h", $time,
                         o_out_item);
            end else begin
                want = deque_outcomes_q.pop_front();
                compare_field("status", want.status, o_out_item.status);
                compare_field("popped_value", want.popped_value, o_out_item.popped_value);
                compare_field("front_value", want.front_value, o_out_item.front_value);
                compare_field("rear_value", want.rear_value, o_out_item.rear_value);
                compare_field("is_empty", want.is_empty, o_out_item.is_empty);
                compare_field("is_full", want.is_full, o_out_item.is_full);
                compare_field("occupancy", want.occupancy, o_out_item.occupancy);
                n_checked++;
            end
        end
    end

    initial begin : out_stall_gen
        int n_open;
        int n_hold;
        forever begin
            n_open = $urandom_range(1, 6);
            i_out_stall <= 1'b0;
            repeat (n_open) @(posedge i_clk);
            n_hold = idle_on ? pick_gap() : 0;
            if (n_hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (n_hold) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_fire || out_fire) quiet = 0;
            else quiet++;
        end
        $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    // rejects on an empty deque, push into empty, pop of the last word
    task automatic test_empty_and_single();
        issue_op(cdq_pkg::OP_POP_FRONT, WORD_MAX);
        issue_op(cdq_pkg::OP_POP_REAR, WORD_MIN);
        issue_op(cdq_pkg::OP_PUSH_FRONT, WORD_MAX);
        issue_op(cdq_pkg::OP_POP_REAR, '0);
        issue_op(cdq_pkg::OP_PUSH_REAR, WORD_MIN);
    endtask

    // front index wraps below zero, fill to full, rejects when full
    task automatic test_fill_and_wrap();
        issue_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::EMPTY_WORD);
        issue_op(cdq_pkg::OP_PUSH_FRONT, '0);
        issue_op(cdq_pkg::OP_PUSH_REAR, 32'h5555_5555);
        issue_op(cdq_pkg::OP_PUSH_REAR, 32'hAAAA_AAAA);
        issue_op(cdq_pkg::OP_PUSH_FRONT, 32'sd1);
        issue_op(cdq_pkg::OP_PUSH_REAR, 32'h1234_5678);
        issue_op(cdq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
        issue_op(cdq_pkg::OP_PUSH_FRONT, 32'sd5);
        issue_op(cdq_pkg::OP_PUSH_REAR, 32'sd6);
    endtask

    // empty from both ends, then pause the sender until all results are back
    task automatic test_drain_alternating();
        for (int k = 0; k < QDEPTH; k++)
            issue_op((k % 2 == 0) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR,
                     rand_word());
        issue_op(cdq_pkg::OP_POP_FRONT, rand_word());
        issue_op(cdq_pkg::OP_POP_REAR, rand_word());
        wait_drained();
    endtask

    task automatic test_random_mix();
        int done;
        int phase_len;
        int push_pct;
        logic [1:0] op;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            phase_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR
                                              : cdq_pkg::OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR
                                              : cdq_pkg::OP_POP_FRONT;
                issue_op(op, rand_word());
                done++;
            end
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_single();
        test_fill_and_wrap();
        test_drain_alternating();
        test_random_mix();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("ran %0d pushes and %0d pops, deque filled %0d times", n_push, n_pop,
                 n_times_full);
        $display("%0d full rejects, %0d empty rejects, %0d results compared",
                 n_full_rej, n_empty_rej, n_checked);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

FILE: circular_deque.f
+incdir+rtl/core
rtl/core/cdq_pkg.sv
rtl/core/cdq_datapath.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_deque.sv
tb/tb_top.sv
